// ===== design/congestion_window_sender_core_macros.svh =====
// ---------------------------------------------------------------------------
// congestion_window_sender_core assertion macros
// concurrent property helpers used by the asserting top-level file
// ---------------------------------------------------------------------------
`ifndef CONGESTION_WINDOW_SENDER_CORE_MACROS_SVH
`define CONGESTION_WINDOW_SENDER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define CWSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, off during reset
`define CWSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/cwsc_pkg.sv =====
// ---------------------------------------------------------------------------
// cwsc_pkg
// shared types, constants and helpers of the congestion window sender core
// ---------------------------------------------------------------------------
`default_nettype none

package cwsc_pkg;

  localparam int unsigned SeqW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned DivW     = 17;
  localparam int unsigned DivCntW  = $clog2(DivW + 1);

  localparam logic [15:0] WinRst     = 16'd30;
  localparam logic [15:0] ThrRst     = 16'd64 << 8;
  localparam logic [7:0]  DupLimRst  = 8'd3;
  localparam logic [31:0] TotalRst   = 32'd0;
  localparam logic [SeqW-1:0] SeqRst = SeqW'(1);
  localparam logic [15:0] FastExtra  = 16'd3;
  localparam logic [DivW-1:0] OneQ16 = DivW'(1) << 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT_WIN  = 2'd0,
    CFG_INIT_THR  = 2'd1,
    CFG_DUP_LIMIT = 2'd2,
    CFG_TOTAL     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_SS = 2'd0,
    MODE_CA = 2'd1,
    MODE_FR = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ACK,
    CMD_CLAMP,
    CMD_GRANT,
    CMD_ADVANCE,
    CMD_TIMEOUT,
    CMD_FAST,
    CMD_NEW,
    CMD_DIV_START,
    CMD_FRAC,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic flag_new;
    logic flag_fast;
    logic mode_ca;
    logic div_done;
  } dp_status_t;

  typedef struct packed {
    logic [5:0]      pad;
    logic            timed_out;
    logic [15:0]     peer_window;
    logic [SeqW-1:0] ack_seq;
    logic            ack_valid;
  } item_t;

  typedef struct packed {
    logic [3:0]      pad;
    logic            all_acked;
    logic [1:0]      phase;
    logic [15:0]     window_now;
    logic [15:0]     grant_count;
    logic [SeqW-1:0] grant_first;
    logic [SeqW-1:0] retransmit_seq;
    logic            retransmit;
  } result_t;

  function automatic logic [15:0] inc_sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] init_win(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

`default_nettype wire

// ===== design/cwsc_div.sv =====
// ---------------------------------------------------------------------------
// cwsc_div
// serial restoring divider: 1.0 in Q1.16 divided by the window, one bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module cwsc_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [15:0]               divisor_i,
  output logic                           done_o,
  output logic [cwsc_pkg::DivW-1:0]      quot_o
);
  import cwsc_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [15:0]        rem_q;
  logic [15:0]        dsr_q;
  logic [DivW-1:0]    dvd_q;
  logic [DivW-1:0]    quo_q;
  logic [16:0]        trial;
  logic [16:0]        diff;
  logic               fits;

  assign trial = {rem_q, dvd_q[DivW-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivW);
    end else if (busy_q) begin
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      dvd_q <= OneQ16;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[15:0] : trial[15:0];
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== design/cwsc_dp.sv =====
// ---------------------------------------------------------------------------
// cwsc_dp
// datapath: window state, config registers, per-step updates and result register
// ---------------------------------------------------------------------------
`default_nettype none

module cwsc_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cwsc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [cwsc_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire cwsc_pkg::item_t                  item_i,
  input  wire cwsc_pkg::cmd_e                   cmd_i,
  output cwsc_pkg::dp_status_t                  status_o,
  output cwsc_pkg::result_t                     result_o
);
  import cwsc_pkg::*;

  // configuration; writes to the threshold index are ignored, the threshold resets to its constant
  logic [15:0] init_win_q;
  logic [7:0]  dup_lim_q;
  logic [31:0] total_q;

  // connection state
  logic [15:0]     win_q, win_d;
  logic [15:0]     thr_q, thr_d;
  mode_e           mode_q, mode_d;
  logic [7:0]      dup_q, dup_d;
  logic [SeqW-1:0] base_q, base_d;
  logic [SeqW-1:0] next_q, next_d;
  logic [31:0]     acked_q, acked_d;
  logic [31:0]     sent_q, sent_d;
  logic [15:0]     frac_q, frac_d;
  logic            fnew_q, fnew_d;
  logic            ffast_q, ffast_d;

  // current item and its partial results
  item_t           item_q;
  logic            rtx_q;
  logic [SeqW-1:0] rtx_seq_q;
  logic [SeqW-1:0] gfirst_q;
  logic [15:0]     gcount_q;
  logic [15:0]     outst_q;
  logic [31:0]     remain_q;
  result_t         out_q;

  logic            div_done;
  logic [DivW-1:0] quot;

  // ack path
  logic [SeqW-1:0] from_prev, ack_dist, ack_outst;
  logic [16:0]     ack_n;
  logic [32:0]     acked_sum;
  logic [7:0]      dup_inc;
  // round path
  logic [15:0]     avail, half_p1, win_inc;
  logic [16:0]     frac_sum;

  cwsc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i == CMD_DIV_START),
    .divisor_i (win_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign from_prev = item_q.ack_seq - (base_q - SeqW'(1));
  assign ack_dist  = item_q.ack_seq - base_q;
  assign ack_outst = next_q - base_q;
  assign ack_n     = {1'b0, ack_dist} + 17'd1;
  assign acked_sum = {1'b0, acked_q} + {16'd0, ack_n};
  assign dup_inc   = (dup_q == 8'hFF) ? dup_q : dup_q + 8'd1;
  assign avail     = (win_q > outst_q) ? win_q - outst_q : 16'd0;
  assign half_p1   = (win_q >> 1) + 16'd1;
  assign win_inc   = inc_sat16(win_q);
  assign frac_sum  = {1'b0, frac_q} + quot;

  always_comb begin
    win_d   = win_q;
    thr_d   = thr_q;
    mode_d  = mode_q;
    dup_d   = dup_q;
    base_d  = base_q;
    next_d  = next_q;
    acked_d = acked_q;
    sent_d  = sent_q;
    frac_d  = frac_q;
    fnew_d  = fnew_q;
    ffast_d = ffast_q;
    unique case (cmd_i)
      CMD_ACK: begin
        if (item_q.ack_valid && (from_prev <= win_q)) begin
          if (ack_dist < ack_outst) begin
            acked_d = acked_sum[32] ? 32'hFFFF_FFFF : acked_sum[31:0];
            base_d  = item_q.ack_seq + SeqW'(1);
            fnew_d  = 1'b1;
          end else if (dup_inc > dup_lim_q) begin
            dup_d   = 8'd0;
            ffast_d = 1'b1;
          end else begin
            dup_d = dup_inc;
          end
        end
      end
      CMD_CLAMP: begin
        if ((item_q.peer_window != 16'd0) && (win_q > item_q.peer_window)) begin
          win_d = item_q.peer_window;
        end
      end
      CMD_ADVANCE: begin
        next_d = next_q + gcount_q;
        sent_d = sent_q + {16'd0, gcount_q};
      end
      CMD_TIMEOUT: begin
        if (item_q.timed_out) begin
          thr_d  = half_p1;
          win_d  = init_win(init_win_q);
          dup_d  = 8'd0;
          mode_d = MODE_SS;
        end
      end
      CMD_FAST: begin
        if (ffast_q) begin
          mode_d = MODE_FR;
          thr_d  = half_p1;
          win_d  = half_p1 + FastExtra;
        end
      end
      CMD_NEW: begin
        if (fnew_q) begin
          dup_d = 8'd0;
          if (mode_q == MODE_FR) begin
            win_d  = init_win(thr_q);
            mode_d = MODE_CA;
          end else if (mode_q == MODE_SS) begin
            win_d = win_inc;
            if (win_inc > thr_q) begin
              mode_d = MODE_CA;
            end
          end
        end
        fnew_d  = 1'b0;
        ffast_d = 1'b0;
      end
      CMD_FRAC: begin
        dup_d  = 8'd0;
        frac_d = frac_sum[15:0];
        if (frac_sum[16]) begin
          win_d = win_inc;
        end
        fnew_d  = 1'b0;
        ffast_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_win_q <= WinRst;
      dup_lim_q  <= DupLimRst;
      total_q    <= TotalRst;
      win_q      <= init_win(WinRst);
      thr_q      <= ThrRst;
      mode_q     <= MODE_SS;
      dup_q      <= '0;
      base_q     <= SeqRst;
      next_q     <= SeqRst;
      acked_q    <= '0;
      sent_q     <= '0;
      frac_q     <= '0;
      fnew_q     <= 1'b0;
      ffast_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_INIT_WIN:  init_win_q <= cfg_data_i[15:0];
          CFG_INIT_THR: begin
          end
          CFG_DUP_LIMIT: dup_lim_q  <= cfg_data_i[7:0];
          CFG_TOTAL:     total_q    <= cfg_data_i;
        endcase
      end
      win_q   <= win_d;
      thr_q   <= thr_d;
      mode_q  <= mode_d;
      dup_q   <= dup_d;
      base_q  <= base_d;
      next_q  <= next_d;
      acked_q <= acked_d;
      sent_q  <= sent_d;
      frac_q  <= frac_d;
      fnew_q  <= fnew_d;
      ffast_q <= ffast_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        item_q    <= item_i;
        rtx_q     <= 1'b0;
        rtx_seq_q <= '0;
        gfirst_q  <= '0;
        gcount_q  <= '0;
      end
      CMD_ACK: begin
        if (item_q.ack_valid && (from_prev <= win_q) && !(ack_dist < ack_outst)
            && (dup_inc > dup_lim_q)) begin
          rtx_q     <= 1'b1;
          rtx_seq_q <= item_q.ack_seq + SeqW'(1);
        end
      end
      CMD_CLAMP: begin
        outst_q  <= next_q - base_q;
        remain_q <= (total_q > sent_q) ? total_q - sent_q : 32'd0;
      end
      CMD_GRANT: begin
        gfirst_q <= next_q;
        gcount_q <= ({16'd0, avail} < remain_q) ? avail : remain_q[15:0];
      end
      CMD_TIMEOUT: begin
        if (item_q.timed_out) begin
          rtx_q     <= 1'b1;
          rtx_seq_q <= base_q;
        end
      end
      CMD_EMIT: begin
        out_q.pad            <= '0;
        out_q.all_acked      <= acked_q >= total_q;
        out_q.phase          <= mode_q;
        out_q.window_now     <= win_q;
        out_q.grant_count    <= gcount_q;
        out_q.grant_first    <= gfirst_q;
        out_q.retransmit_seq <= rtx_seq_q;
        out_q.retransmit     <= rtx_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.flag_new  = fnew_q;
  assign status_o.flag_fast = ffast_q;
  assign status_o.mode_ca   = (mode_q == MODE_CA);
  assign status_o.div_done  = div_done;
  assign result_o           = out_q;

endmodule

`default_nettype wire

// ===== design/cwsc_ctrl.sv =====
// ---------------------------------------------------------------------------
// cwsc_ctrl
// controller: sequences ack and round-end steps and owns the handshakes
// ---------------------------------------------------------------------------
`default_nettype none

module cwsc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_round_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire cwsc_pkg::dp_status_t  status_i,
  output cwsc_pkg::cmd_e             cmd_o
);
  import cwsc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK,
    ST_CLAMP,
    ST_GRANT,
    ST_ADVANCE,
    ST_TIMEOUT,
    ST_FAST,
    ST_NEW,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = in_round_i ? ST_CLAMP : ST_ACK;
        end
      end
      ST_ACK: begin
        cmd_o   = CMD_ACK;
        state_d = ST_OUT;
      end
      ST_CLAMP: begin
        cmd_o   = CMD_CLAMP;
        state_d = ST_GRANT;
      end
      ST_GRANT: begin
        cmd_o   = CMD_GRANT;
        state_d = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        cmd_o   = CMD_ADVANCE;
        state_d = ST_TIMEOUT;
      end
      ST_TIMEOUT: begin
        cmd_o   = CMD_TIMEOUT;
        state_d = ST_FAST;
      end
      ST_FAST: begin
        cmd_o   = CMD_FAST;
        state_d = ST_NEW;
      end
      ST_NEW: begin
        if (status_i.flag_new && status_i.mode_ca) begin
          cmd_o   = CMD_DIV_START;
          state_d = ST_DIV;
        end else begin
          cmd_o   = CMD_NEW;
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o   = CMD_FRAC;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o       = CMD_EMIT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/congestion_window_sender_core.sv =====
// ---------------------------------------------------------------------------
// congestion_window_sender_core
// reno-style sender window: cumulative acks, duplicate counting, grants per round
//
//   channel   direction  tdata fields (low bit up)                    tuser
//   s_axis    in         ack_valid, ack_seq, peer_window, timed_out  action
//   m_axis    out        retransmit, retransmit_seq, grant_first,    -
//                        grant_count, window_now, phase, all_acked
//   cfg       in         write enable, index, data (no read-back)    -
//
// ack item: loaded on acceptance, then the ack step, then the output step registers the result
// round end: clamp, grant, advance, timeout, fast, new-ack and output steps, plus a divide
//   when congestion avoidance sees a new ack, run by the 17-step serial divider for the window reciprocal
// one item in flight; next item taken as soon as its result sits in the output register
// a stalled result holds the controller in its output step
// ready right after reset, no memory to clear
// ---------------------------------------------------------------------------
`default_nettype none

`include "congestion_window_sender_core_macros.svh"

module congestion_window_sender_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // ack_valid[0], ack_seq[16:1], peer_window[32:17], timed_out[33], zero pad
  input  wire logic [cwsc_pkg::InDataW-1:0]     s_axis_tdata,
  // action[0]
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // retransmit[0], retransmit_seq[16:1], grant_first[32:17], grant_count[48:33],
  // window_now[64:49], phase[66:65], all_acked[67], zero pad
  output logic [cwsc_pkg::OutDataW-1:0]         m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [cwsc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [cwsc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import cwsc_pkg::*;

  cmd_e       cmd;
  dp_status_t status;
  result_t    result;

  cwsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_round_i  (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cwsc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_t'(s_axis_tdata)),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result)
  );

  assign m_axis_tdata = result;

  // the window never drops to zero
  `CWSC_ASSERT_IMP(a_win_nonzero, clk_i, rst_ni, m_axis_tvalid, result.window_now != 16'd0)
  // no retransmit, no sequence number
  `CWSC_ASSERT_IMP(a_rtx_seq_zero, clk_i, rst_ni, m_axis_tvalid && !result.retransmit,
                   result.retransmit_seq == '0)
  // one item at a time
  `CWSC_ASSERT_NXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire
